// ===== sv/dtp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtp_pkg
// Shared types, constants and helpers of the disparity to point cloud block.
// ----------------------------------------------------------------------------
package dtp_pkg;

  // pixel bounds
  localparam int MAX_COLUMNS = 4096;
  localparam int MAX_ROWS    = 4096;
  localparam int PIX_W       = 12;

  // smallest disparity used, raw Q9.8
  localparam int DISP_MIN = 26;

  // long division sizes
  localparam int QW    = 33;        // quotient bits kept before saturation
  localparam int NW    = 60;        // rounded numerator magnitude
  localparam int DW    = 37;        // divisor
  localparam int SW    = DW + QW;   // widest shifted divisor
  localparam int LANES = 3;         // x, y and z
  localparam int NSTG  = QW;        // one quotient bit per stage

  // register map
  localparam int ADDR_W = 6;
  localparam int DATA_W = 64;

  typedef enum logic [2:0] {
    REG_FOCAL_X     = 3'd0,
    REG_FOCAL_Y     = 3'd1,
    REG_PRINCIPAL   = 3'd2,
    REG_BASELINE    = 3'd3,
    REG_ROT_ROW0    = 3'd4,
    REG_ROT_ROW1    = 3'd5,
    REG_ROT_ROW2    = 3'd6,
    REG_TRANSLATION = 3'd7
  } dtp_reg_t;

  // one divider lane
  typedef struct packed {
    logic [NW-1:0] rem;
    logic [DW-1:0] den;
    logic          neg;
    logic          ovf;
    logic [QW-1:0] quo;
  } dtp_lane_t;

  // signed 32-bit result of a rounded quotient, saturated
  function automatic logic signed [31:0] sat_quo(input dtp_lane_t l);
    logic signed [31:0] res;
    if (!l.neg) begin
      res = (l.ovf || l.quo > 33'h07FFFFFFF) ? 32'sh7FFFFFFF : $signed(l.quo[31:0]);
    end else begin
      res = (l.ovf || l.quo > 33'h080000000) ? 32'sh80000000 : -$signed(l.quo[31:0]);
    end
    return res;
  endfunction

  // saturate a 37-bit signed sum to 32 bits
  function automatic logic signed [31:0] sat_37(input logic signed [36:0] v);
    logic signed [31:0] res;
    if (v > 37'sh007FFFFFFF) begin
      res = 32'sh7FFFFFFF;
    end else if (v < -37'sh0080000000) begin
      res = 32'sh80000000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

// ===== sv/dtp_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtp_div
// Three-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module dtp_div import dtp_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  dtp_lane_t [LANES-1:0]        in_lane,
  output logic                         out_valid,
  input  logic                         out_ready,
  output dtp_lane_t [LANES-1:0]        out_lane
);

  dtp_lane_t [LANES-1:0] stg_q [NSTG];
  logic                  stg_v [NSTG];
  logic                  stg_rdy [NSTG+1];

  assign stg_rdy[NSTG] = out_ready;

  for (genvar k = 0; k < NSTG; k++) begin : g_stg
    localparam int BIT = QW - 1 - k;
    dtp_lane_t [LANES-1:0] src;
    dtp_lane_t [LANES-1:0] nxt;
    logic                  src_v;

    if (k == 0) begin : g_first
      assign src   = in_lane;
      assign src_v = in_valid;
    end else begin : g_rest
      assign src   = stg_q[k-1];
      assign src_v = stg_v[k-1];
    end

    assign stg_rdy[k] = !stg_v[k] || stg_rdy[k+1];

    // compare and subtract the shifted divisor
    always_comb begin
      logic [SW-1:0] shd;
      logic          ge;
      for (int i = 0; i < LANES; i++) begin
        nxt[i] = src[i];
        shd    = SW'(src[i].den) << BIT;
        ge     = SW'(src[i].rem) >= shd;
        if (ge) begin
          nxt[i].rem = src[i].rem - shd[NW-1:0];
        end
        nxt[i].quo[BIT] = ge;
        if (k == 0) begin
          nxt[i].ovf = SW'(src[i].rem) >= (SW'(src[i].den) << QW);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stg_v[k] <= 1'b0;
      end else if (stg_rdy[k]) begin
        stg_v[k] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (stg_rdy[k] && src_v) begin
        stg_q[k] <= nxt;
      end
    end
  end

  assign in_ready  = stg_rdy[0];
  assign out_valid = stg_v[NSTG-1];
  assign out_lane  = stg_q[NSTG-1];

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    stg_v[NSTG-1] && !out_ready |=> stg_v[NSTG-1] && $stable(stg_q[NSTG-1]))
    else $error("divider result changed while stalled");

  // only the top quotient bit is decided after the first stage
  a_first: assert property (@(posedge clk) disable iff (rst)
    stg_v[0] |-> stg_q[0][0].quo[QW-2:0] == '0)
    else $error("low quotient bits set too early");

  // remainder ends below the divisor
  a_rem: assert property (@(posedge clk) disable iff (rst)
    stg_v[NSTG-1] && !stg_q[NSTG-1][0].ovf && !stg_q[NSTG-1][1].ovf
      && !stg_q[NSTG-1][2].ovf
    |-> SW'(stg_q[NSTG-1][0].rem) < SW'(stg_q[NSTG-1][0].den)
     && SW'(stg_q[NSTG-1][1].rem) < SW'(stg_q[NSTG-1][1].den)
     && SW'(stg_q[NSTG-1][2].rem) < SW'(stg_q[NSTG-1][2].den))
    else $error("remainder not reduced");

endmodule

// ===== sv/disparity_to_point_cloud.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// disparity_to_point_cloud
// Triangulates a pixel and its disparity into a rigidly transformed 3-D point.
// ----------------------------------------------------------------------------
//  channel   handshake              beat contents
//  in        in_valid / in_ready    pixel_column, pixel_row, disparity_value
//  out       out_valid / out_ready  point_x, point_y, point_z (Q16.16)
//  cfg       psel / penable / pwrite paddr, pwdata, prdata (64-bit registers)
//
//  one beat per clock is accepted while the output is not stalled; the path
//  has four setup and multiply stages, 33 stages of the three-lane divider (one quotient bit
//  each), then saturate, rotate-multiply and sum stages.
//  rst is synchronous; it clears all valid bits and loads register defaults.
//  each stage loads whenever it is empty or its successor moves, so bubbles
//  close up and a stalled output holds without losing a beat.
// ----------------------------------------------------------------------------
module disparity_to_point_cloud import dtp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [PIX_W-1:0]         pixel_column,
  input  logic [PIX_W-1:0]         pixel_row,
  input  logic signed [16:0]       disparity_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [31:0]       point_x,
  output logic signed [31:0]       point_y,
  output logic signed [31:0]       point_z,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready
);

  localparam logic [PIX_W-1:0] COL_LAST = PIX_W'(MAX_COLUMNS - 1);
  localparam logic [PIX_W-1:0] ROW_LAST = PIX_W'(MAX_ROWS - 1);

  logic [19:0] focal_x;
  logic [19:0] focal_y;
  logic [31:0] principal_point;
  logic [17:0] stereo_baseline;
  logic [47:0] rotation_row0;
  logic [47:0] rotation_row1;
  logic [47:0] rotation_row2;
  logic [47:0] translation;

  dtp_reg_t reg_idx;
  logic     cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = dtp_reg_t'(paddr[ADDR_W-1:3]);
  assign cfg_wr  = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x         <= 20'd128000;
      focal_y         <= 20'd128000;
      principal_point <= '0;
      stereo_baseline <= 18'd7864;
      rotation_row0   <= 48'h0000_0000_4000;
      rotation_row1   <= 48'h0000_4000_0000;
      rotation_row2   <= 48'h4000_0000_0000;
      translation     <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_FOCAL_X:     focal_x         <= pwdata[19:0];
        REG_FOCAL_Y:     focal_y         <= pwdata[19:0];
        REG_PRINCIPAL:   principal_point <= pwdata[31:0];
        REG_BASELINE:    stereo_baseline <= pwdata[17:0];
        REG_ROT_ROW0:    rotation_row0   <= pwdata[47:0];
        REG_ROT_ROW1:    rotation_row1   <= pwdata[47:0];
        REG_ROT_ROW2:    rotation_row2   <= pwdata[47:0];
        REG_TRANSLATION: translation     <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (reg_idx)
      REG_FOCAL_X:     prdata = DATA_W'(focal_x);
      REG_FOCAL_Y:     prdata = DATA_W'(focal_y);
      REG_PRINCIPAL:   prdata = DATA_W'(principal_point);
      REG_BASELINE:    prdata = DATA_W'(stereo_baseline);
      REG_ROT_ROW0:    prdata = DATA_W'(rotation_row0);
      REG_ROT_ROW1:    prdata = DATA_W'(rotation_row1);
      REG_ROT_ROW2:    prdata = DATA_W'(rotation_row2);
      REG_TRANSLATION: prdata = DATA_W'(translation);
      default:         prdata = '0;
    endcase
  end

  logic [19:0] fy_eff;
  assign fy_eff = (focal_y == '0) ? 20'd1 : focal_y;

  // stage ready chain
  logic s1_v, s2_v, s3_v, s4_v, r1_v, r2_v;
  logic s1_rdy, s2_rdy, s3_rdy, s4_rdy, r1_rdy, r2_rdy, o_rdy;
  logic div_in_rdy, div_out_v;

  assign o_rdy    = !out_valid || out_ready;
  assign r2_rdy   = !r2_v || o_rdy;
  assign r1_rdy   = !r1_v || r2_rdy;
  assign s4_rdy   = !s4_v || div_in_rdy;
  assign s3_rdy   = !s3_v || s4_rdy;
  assign s2_rdy   = !s2_v || s3_rdy;
  assign s1_rdy   = !s1_v || s2_rdy;
  assign in_ready = s1_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      s3_v      <= 1'b0;
      s4_v      <= 1'b0;
      r1_v      <= 1'b0;
      r2_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_rdy) s1_v <= in_valid;
      if (s2_rdy) s2_v <= s1_v;
      if (s3_rdy) s3_v <= s2_v;
      if (s4_rdy) s4_v <= s3_v;
      if (r1_rdy) r1_v <= div_out_v;
      if (r2_rdy) r2_v <= r1_v;
      if (o_rdy)  out_valid <= r2_v;
    end
  end

  // stage 1: clamp pixel and disparity, offsets from the principal point
  logic [PIX_W-1:0]   col_c, row_c;
  logic [15:0]        d_c;
  logic [15:0]        s1_d;
  logic signed [17:0] s1_xr, s1_yr;

  assign col_c = (pixel_column > COL_LAST) ? COL_LAST : pixel_column;
  assign row_c = (pixel_row > ROW_LAST) ? ROW_LAST : pixel_row;
  assign d_c   = (disparity_value < 17'(DISP_MIN)) ? 16'(DISP_MIN) : disparity_value[15:0];

  always_ff @(posedge clk) begin
    if (s1_rdy && in_valid) begin
      s1_d  <= d_c;
      s1_xr <= $signed({2'b00, col_c, 4'b0000}) - $signed({2'b00, principal_point[15:0]});
      s1_yr <= $signed({2'b00, row_c, 4'b0000}) - $signed({2'b00, principal_point[31:16]});
    end
  end

  // stage 2: baseline times focal, y term, z divisor
  logic [37:0]        s2_bfx;
  logic signed [23:0] s2_t;
  logic [35:0]        s2_zden;
  logic signed [17:0] s2_yr;
  logic [15:0]        s2_d;

  always_ff @(posedge clk) begin
    if (s2_rdy && s1_v) begin
      s2_bfx  <= 38'(stereo_baseline) * 38'(focal_x);
      s2_t    <= (24'(s1_xr) <<< 5) + $signed({8'h00, s1_d});
      s2_zden <= 36'(fy_eff) * 36'(s1_d);
      s2_yr   <= s1_yr;
      s2_d    <= s1_d;
    end
  end

  // stage 3: y and z numerators
  logic signed [42:0] s3_bt;
  logic signed [55:0] s3_bfxyr;
  logic [37:0]        s3_bfx;
  logic [35:0]        s3_zden;
  logic [15:0]        s3_d;

  always_ff @(posedge clk) begin
    if (s3_rdy && s2_v) begin
      s3_bt    <= 43'($signed({1'b0, stereo_baseline})) * 43'(s2_t);
      s3_bfxyr <= 56'($signed({1'b0, s2_bfx})) * 56'(s2_yr);
      s3_bfx   <= s2_bfx;
      s3_zden  <= s2_zden;
      s3_d     <= s2_d;
    end
  end

  // stage 4: magnitudes plus half divisor for rounding
  dtp_lane_t [LANES-1:0] lane_nxt, s4_lane, div_out;
  logic [42:0]           bt_mag;
  logic [55:0]           z_mag;

  assign bt_mag = s3_bt[42] ? 43'(-s3_bt) : 43'(s3_bt);
  assign z_mag  = s3_bfxyr[55] ? 56'(-s3_bfxyr) : 56'(s3_bfxyr);

  always_comb begin
    lane_nxt        = '0;
    lane_nxt[0].rem = NW'(s3_bfx) + NW'(s3_d >> 1);
    lane_nxt[0].den = DW'(s3_d);
    lane_nxt[1].rem = NW'(bt_mag) + NW'(s3_d);
    lane_nxt[1].den = DW'({s3_d, 1'b0});
    lane_nxt[1].neg = !s3_bt[42] && (s3_bt != '0);
    lane_nxt[2].rem = {z_mag, 4'b0000} + NW'(s3_zden >> 1);
    lane_nxt[2].den = DW'(s3_zden);
    lane_nxt[2].neg = s3_bfxyr[55];
  end

  always_ff @(posedge clk) begin
    if (s4_rdy && s3_v) begin
      s4_lane <= lane_nxt;
    end
  end

  dtp_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s4_v),
    .in_ready  (div_in_rdy),
    .in_lane   (s4_lane),
    .out_valid (div_out_v),
    .out_ready (r1_rdy),
    .out_lane  (div_out)
  );

  // r1: saturate camera-frame point
  logic signed [31:0] r1_c [LANES];

  always_ff @(posedge clk) begin
    if (r1_rdy && div_out_v) begin
      for (int i = 0; i < LANES; i++) begin
        r1_c[i] <= sat_quo(div_out[i]);
      end
    end
  end

  // r2: rotation products
  logic [47:0]        rot_row [LANES];
  logic signed [47:0] r2_p [LANES][LANES];

  assign rot_row[0] = rotation_row0;
  assign rot_row[1] = rotation_row1;
  assign rot_row[2] = rotation_row2;

  always_ff @(posedge clk) begin
    if (r2_rdy && r1_v) begin
      for (int j = 0; j < LANES; j++) begin
        for (int i = 0; i < LANES; i++) begin
          r2_p[j][i] <= 48'($signed(rot_row[j][16*i +: 16])) * 48'(r1_c[i]);
        end
      end
    end
  end

  // r3: row sums, rounding shift, translation, saturate
  logic signed [31:0] pt_nxt [LANES];

  always_comb begin
    logic signed [49:0] sum;
    logic signed [35:0] sh;
    logic signed [36:0] tot;
    for (int j = 0; j < LANES; j++) begin
      sum       = 50'(r2_p[j][0]) + 50'(r2_p[j][1]) + 50'(r2_p[j][2]) + 50'sd8192;
      sh        = 36'(sum >>> 14);
      tot       = 37'(sh) + 37'($signed({translation[16*j +: 16], 8'h00}));
      pt_nxt[j] = sat_37(tot);
    end
  end

  always_ff @(posedge clk) begin
    if (o_rdy && r2_v) begin
      point_x <= pt_nxt[0];
      point_y <= pt_nxt[1];
      point_z <= pt_nxt[2];
    end
  end

  // reset empties the output
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // an empty first stage always takes a beat
  a_take: assert property (@(posedge clk) disable iff (rst) !s1_v |-> in_ready)
    else $error("input refused with empty first stage");

  // a held beat in the first stage is not dropped
  a_keep: assert property (@(posedge clk) disable iff (rst)
    s1_v && !s2_rdy |=> s1_v && $stable(s1_d))
    else $error("first stage beat lost while stalled");

endmodule
